/* rtl/hwm_pkg.sv */
// ----------------------------------------------------------------------------
// hwm_pkg
// Shared widths, constants and types of the histogram with mode block.
// ----------------------------------------------------------------------------
package hwm_pkg;

   localparam int VALUE_WIDTH      = 5;
   localparam int NUM_VALUES       = 32;
   localparam int CFG_WIDTH        = 6;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 6'd26;
   localparam int FIELD_CNT_WIDTH  = 16;
   localparam int REQ_DATA_WIDTH   = 8;
   localparam int RSP_DATA_WIDTH   = 48;
   localparam int DEF_MAX_BINS     = 32;
   localparam int DEF_COUNT_WIDTH  = 16;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DRAIN,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } hwm_state_type;

endpackage

/* rtl/hwm_ram.sv */
// ----------------------------------------------------------------------------
// hwm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module hwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/histogram_with_mode.sv */
// ----------------------------------------------------------------------------
// histogram_with_mode
// Counts samples into saturating bins held in a RAM, tracks the mode, and
// emits one result per bin in use after the last sample of a set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while no set is being emitted; each passes a
// read-modify-write of its bin with forwarding from the previous write.
// After the last sample the pipeline drains, then each bin in turn passes a
// RAM read, a load and a send (RAM read, load, send; the send waits for rsp_tready).
// New samples are blocked from the last sample until the final result is taken.
// Reset is synchronous; it clears the control state and the per-bin valid
// flags at once, so the RAM needs no clearing pass.
module histogram_with_mode #(
   parameter int MAX_BINS    = hwm_pkg::DEF_MAX_BINS,
   parameter int COUNT_WIDTH = hwm_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from the lowest up: sample_value[4:0], zero padding[7:5].
   input  logic [hwm_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from the lowest up: bin_index[4:0], bin_count[20:5],
   // mode_value[25:21], mode_count[41:26], zero padding[47:42].
   output logic [hwm_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [hwm_pkg::CFG_WIDTH-1:0]       csr_wr_data
);

   import hwm_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int EFF_LIMIT = (MAX_BINS < NUM_VALUES) ? MAX_BINS : NUM_VALUES;
   localparam logic [CFG_WIDTH-1:0] EFF_MAX = CFG_WIDTH'(EFF_LIMIT);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam int PAD_WIDTH = RSP_DATA_WIDTH - 2 * VALUE_WIDTH - 2 * FIELD_CNT_WIDTH;

   hwm_state_type state_ff, state_in;

   logic [CFG_WIDTH-1:0]   bins_ff;
   logic [CFG_WIDTH-1:0]   eff_bins;
   logic [NUM_VALUES-1:0]  valid_ff, valid_in;

   logic                   s1_valid_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;
   logic                   wr_valid_ff;
   logic [VALUE_WIDTH-1:0] wr_value_ff;
   logic [COUNT_WIDTH-1:0] wr_count_ff;
   logic [VALUE_WIDTH-1:0] best_value_ff, best_value_in;
   logic [COUNT_WIDTH-1:0] best_count_ff, best_count_in;

   logic [CFG_WIDTH-1:0]   bin_idx_ff, bin_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] out_index_ff, out_index_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;
   logic [VALUE_WIDTH-1:0] out_mode_ff, out_mode_in;
   logic [COUNT_WIDTH-1:0] out_mode_cnt_ff, out_mode_cnt_in;
   logic                   out_last_ff, out_last_in;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] sample_value;
   logic                   in_range;
   logic                   rd_en;
   logic [31:0]            rd_wide;
   logic [AW-1:0]          rd_addr;
   logic [31:0]            wr_wide;
   logic [AW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] old_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   scan_last;
   logic                   clear_set;
   logic [VALUE_WIDTH-1:0] scan_value;
   logic [31:0]            out_count_wide;
   logic [31:0]            out_mode_wide;

   always_comb begin
      eff_bins = bins_ff;
      if (eff_bins == '0) begin
         eff_bins = CFG_WIDTH'(1);
      end
      if (eff_bins > EFF_MAX) begin
         eff_bins = EFF_MAX;
      end
   end

   assign sample_value = req_tdata[VALUE_WIDTH-1:0];
   assign req_tready   = (state_ff == ST_RUN);
   assign accept       = req_tvalid && req_tready;
   assign in_range     = {1'b0, sample_value} < eff_bins;
   assign scan_value   = bin_idx_ff[VALUE_WIDTH-1:0];
   assign scan_last    = (bin_idx_ff + CFG_WIDTH'(1)) == eff_bins;

   always_comb begin
      if (state_ff == ST_READ) begin
         rd_wide = 32'(scan_value);
         rd_en   = 1'b1;
      end else begin
         rd_wide = 32'(sample_value);
         rd_en   = accept && in_range;
      end
   end

   assign rd_addr = rd_wide[AW-1:0];
   assign wr_wide = 32'(s1_value_ff);
   assign wr_addr = wr_wide[AW-1:0];

   hwm_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(MAX_BINS)
   ) u_bins (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(wr_addr),
      .wr_data(new_count),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      if (wr_valid_ff && (wr_value_ff == s1_value_ff)) begin
         old_count = wr_count_ff;
      end else if (valid_ff[s1_value_ff]) begin
         old_count = rd_data;
      end else begin
         old_count = '0;
      end
      new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_WIDTH'(1);
   end

   always_comb begin
      state_in        = state_ff;
      bin_idx_in      = bin_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_index_in    = out_index_ff;
      out_count_in    = out_count_ff;
      out_mode_in     = out_mode_ff;
      out_mode_cnt_in = out_mode_cnt_ff;
      out_last_in     = out_last_ff;
      clear_set       = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            out_index_in    = scan_value;
            out_count_in    = valid_ff[scan_value] ? rd_data : '0;
            out_mode_in     = best_value_ff;
            out_mode_cnt_in = best_count_ff;
            out_last_in     = scan_last;
            rsp_valid_in    = 1'b1;
            state_in        = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  clear_set  = 1'b1;
                  bin_idx_in = '0;
                  state_in   = ST_RUN;
               end else begin
                  bin_idx_in = bin_idx_ff + CFG_WIDTH'(1);
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      valid_in      = valid_ff;
      best_value_in = best_value_ff;
      best_count_in = best_count_ff;
      if (clear_set) begin
         valid_in      = '0;
         best_value_in = '0;
         best_count_in = '0;
      end else if (s1_valid_ff) begin
         valid_in[s1_value_ff] = 1'b1;
         if (new_count >= best_count_ff) begin
            best_value_in = s1_value_ff;
            best_count_in = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         bins_ff       <= CFG_RESET;
         valid_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         best_value_ff <= '0;
         best_count_ff <= '0;
         bin_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            bins_ff <= csr_wr_data;
         end
         valid_ff      <= valid_in;
         s1_valid_ff   <= accept && in_range;
         wr_valid_ff   <= s1_valid_ff;
         best_value_ff <= best_value_in;
         best_count_ff <= best_count_in;
         bin_idx_ff    <= bin_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff     <= sample_value;
      wr_value_ff     <= s1_value_ff;
      wr_count_ff     <= new_count;
      out_index_ff    <= out_index_in;
      out_count_ff    <= out_count_in;
      out_mode_ff     <= out_mode_in;
      out_mode_cnt_ff <= out_mode_cnt_in;
      out_last_ff     <= out_last_in;
   end

   assign out_count_wide = 32'(out_count_ff);
   assign out_mode_wide  = 32'(out_mode_cnt_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{PAD_WIDTH{1'b0}},
                        out_mode_wide[FIELD_CNT_WIDTH-1:0],
                        out_mode_ff,
                        out_count_wide[FIELD_CNT_WIDTH-1:0],
                        out_index_ff};

endmodule

/* rtl/hwm_checker.sv */
// ----------------------------------------------------------------------------
// hwm_checker
// Port-level assertions for the histogram with mode block, bound to its top.
// ----------------------------------------------------------------------------
module hwm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tlast,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hwm_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input logic                                rsp_tlast
);

   import hwm_pkg::*;

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // No sample is taken while a result is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("sample accepted during emission");

   // The last sample of a set stops intake for the emission.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (!req_tready && !rsp_tvalid))
      else $error("intake continued after last sample");

   // After the final bin the block returns to intake with no result pending.
   a_end_of_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("emission did not end after final bin");

endmodule

bind histogram_with_mode hwm_checker u_hwm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast (req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
